[rtl/hbd_pkg.sv]
// Shared constants for the Huffman tree build and decode block.
`timescale 1ns / 1ps
package hbd_pkg;
  localparam int unsigned MaxLeavesDef = 256;

  // input item operation codes
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_BUILD  = 2'd1;
  localparam logic [1:0] MODE_DECODE = 2'd2;

  // configuration register indexes
  localparam logic REG_LEAF_COUNT   = 1'b0;
  localparam logic REG_SYMBOL_TOTAL = 1'b1;

  localparam logic [8:0] LeafCountReset = 9'd2;
endpackage

[rtl/huffman_tree_build_and_decode_top.sv]
// Huffman tree build and decode: leaf load, tree build sequencer, bit walker.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------------
//  in       | sink      | in_valid/in_ready  | mode, leaf_index, symbol_in, weight,
//           |           |                    | code_byte
//  out      | source    | out_valid/out_ready| symbol_out, last_of_byte, stream_done
//  apb      | slave     | psel/penable       | leaf_count (0x0), symbol_total (0x4)
//
// A decode byte runs, for each bit of walk, a child memory read, then a select,
// plus a step per emitted symbol, plus the transfer, the end-of-byte step and
// the flush. A build clears the used flags of nodes 0..2n-2, then per merge
// runs two scans (reads, registered read, mark) over weight memory nodes 0..i-1.
// Reset clears control state only; memory contents stay undefined until written.
// The input stalls while an item is in work; a stalled output holds the walker.
`timescale 1ns / 1ps
module huffman_tree_build_and_decode_top
  import hbd_pkg::*;
#(
  parameter int unsigned MaxLeaves = MaxLeavesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  leaf_index_i,
  input  logic [7:0]  symbol_in_i,
  input  logic [31:0] weight_i,
  input  logic [7:0]  code_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  symbol_out_o,
  output logic        last_of_byte_o,
  output logic        stream_done_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int unsigned NodeDepth  = 2 * MaxLeaves - 1;
  localparam int unsigned InnerDepth = MaxLeaves - 1;
  localparam int unsigned Nw = $clog2(NodeDepth + 1);
  localparam int unsigned Iw = (InnerDepth > 1) ? $clog2(InnerDepth) : 1;
  localparam int unsigned Lw = (MaxLeaves > 1) ? $clog2(MaxLeaves) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_SCAN, S_MARK, S_DEC, S_DCH, S_DSYM, S_FIN
  } state_e;

  state_e         state_q;
  logic [8:0]     leaf_count_q;
  logic [31:0]    symbol_total_q;
  logic [Nw-1:0]  bn_q, walk_q, bi_q, scan_j_q, pend_idx_q, best_q, a_q, clr_q;
  logic           pend_q, found_q, second_q, tree_ready_q;
  logic [31:0]    emitted_q, best_w_q, wa_q;
  logic [7:0]     byte_q;
  logic [3:0]     bit_q;
  logic           hold_valid_q, hold_done_q, new_done_q;
  logic [7:0]     hold_sym_q;
  logic           out_valid_q, out_last_q, out_done_q;
  logic [7:0]     out_sym_q;

  // memory ports
  logic            sym_we, sym_re, wgt_we, wgt_re, used_we, used_re, ch_we, ch_re;
  logic [Lw-1:0]   sym_waddr, sym_raddr;
  logic [7:0]      sym_rdata;
  logic [Nw-1:0]   wgt_waddr, used_waddr;
  logic [31:0]     wgt_wdata, wgt_rdata;
  logic            used_wdata, used_rdata;
  logic [Iw-1:0]   ch_waddr, ch_raddr;
  logic [2*Nw-1:0] ch_rdata;

  logic [Nw-1:0]  root, n_clamp, inner_full, nxt;
  logic [32:0]    sum;
  logic           in_acc, out_free, scan_more, total_hit;

  hbd_ram #(.Width(8), .Depth(MaxLeaves)) u_sym (
    .clk_i, .we_i(sym_we), .waddr_i(sym_waddr), .wdata_i(symbol_in_i),
    .re_i(sym_re), .raddr_i(sym_raddr), .rdata_o(sym_rdata));
  hbd_ram #(.Width(32), .Depth(NodeDepth)) u_wgt (
    .clk_i, .we_i(wgt_we), .waddr_i(wgt_waddr[Nw-1:0]), .wdata_i(wgt_wdata),
    .re_i(wgt_re), .raddr_i(scan_j_q), .rdata_o(wgt_rdata));
  hbd_ram #(.Width(1), .Depth(NodeDepth)) u_used (
    .clk_i, .we_i(used_we), .waddr_i(used_waddr), .wdata_i(used_wdata),
    .re_i(used_re), .raddr_i(scan_j_q), .rdata_o(used_rdata));
  hbd_ram #(.Width(2 * Nw), .Depth(InnerDepth)) u_child (
    .clk_i, .we_i(ch_we), .waddr_i(ch_waddr), .wdata_i({a_q, best_q}),
    .re_i(ch_re), .raddr_i(ch_raddr), .rdata_o(ch_rdata));

  // APB register file
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SYMBOL_TOTAL) ? symbol_total_q : {23'd0, leaf_count_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leaf_count_q   <= LeafCountReset;
      symbol_total_q <= '0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_SYMBOL_TOTAL) begin
        symbol_total_q <= pwdata;
      end else begin
        leaf_count_q <= pwdata[8:0];
      end
    end
  end

  // datapath helpers
  assign root      = Nw'({bn_q, 1'b0} - 2);
  assign n_clamp   = (leaf_count_q < 9'd2) ? Nw'(2) :
                     ({1'b0, leaf_count_q} > 10'(MaxLeaves)) ? Nw'(MaxLeaves) :
                     Nw'(leaf_count_q);
  assign inner_full = (walk_q < bn_q || (walk_q - bn_q) >= Nw'(InnerDepth)) ?
                      Nw'(root - bn_q) : Nw'(walk_q - bn_q);
  assign nxt       = byte_q[7] ? ch_rdata[Nw-1:0] : ch_rdata[2*Nw-1:Nw];
  assign sum       = {1'b0, wa_q} + {1'b0, best_w_q};
  assign in_acc    = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;
  assign scan_more = scan_j_q < bi_q;
  assign total_hit = emitted_q >= symbol_total_q;
  assign in_ready_o = (state_q == S_IDLE);

  // memory port control
  always_comb begin
    // loads to a slot past the leaf range are dropped
    sym_we     = in_acc && (mode_i == MODE_LOAD) &&
                 ({1'b0, leaf_index_i} < 9'(MaxLeaves));
    sym_waddr  = leaf_index_i[Lw-1:0];
    sym_re     = (state_q == S_DCH) && (nxt < bn_q);
    sym_raddr  = nxt[Lw-1:0];
    wgt_we     = 1'b0;
    wgt_waddr  = Nw'(leaf_index_i);
    wgt_wdata  = weight_i;
    if (sym_we) begin
      wgt_we = 1'b1;
    end else if (state_q == S_MARK && second_q) begin
      wgt_we    = 1'b1;
      wgt_waddr = bi_q;
      wgt_wdata = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    end
    wgt_re     = (state_q == S_SCAN) && scan_more;
    used_re    = wgt_re;
    used_we    = (state_q == S_CLR) || (state_q == S_MARK);
    used_waddr = (state_q == S_CLR) ? clr_q : best_q;
    used_wdata = (state_q == S_MARK);
    ch_we      = (state_q == S_MARK) && second_q;
    ch_waddr   = Iw'(bi_q - bn_q);
    ch_re      = (state_q == S_DEC) && !(bit_q == 4'd8) && !total_hit;
    ch_raddr   = Iw'(inner_full);
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      bn_q         <= Nw'(2);
      walk_q       <= '0;
      emitted_q    <= '0;
      tree_ready_q <= 1'b0;
      pend_q       <= 1'b0;
      found_q      <= 1'b0;
      second_q     <= 1'b0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      bi_q         <= '0;
      scan_j_q     <= '0;
      clr_q        <= '0;
      bit_q        <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (mode_i == MODE_BUILD) begin
              bn_q    <= n_clamp;
              clr_q   <= '0;
              state_q <= S_CLR;
            end else if (mode_i == MODE_DECODE && tree_ready_q) begin
              byte_q  <= code_byte_i;
              bit_q   <= '0;
              state_q <= S_DEC;
            end
          end
        end
        // clear used flags of every node the build touches
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == root) begin
            bi_q     <= bn_q;
            scan_j_q <= '0;
            pend_q   <= 1'b0;
            found_q  <= 1'b0;
            second_q <= 1'b0;
            state_q  <= S_SCAN;
          end
        end
        // lightest unused node among 0..i-1, first by index
        S_SCAN: begin
          if (scan_more) begin
            scan_j_q <= scan_j_q + 1'b1;
          end
          pend_q     <= scan_more;
          pend_idx_q <= scan_j_q;
          if (pend_q && !used_rdata && (!found_q || wgt_rdata < best_w_q)) begin
            best_q   <= pend_idx_q;
            best_w_q <= wgt_rdata;
            found_q  <= 1'b1;
          end
          if (!scan_more && !pend_q) begin
            state_q <= S_MARK;
          end
        end
        // mark the pick; after the second pick merge into node i
        S_MARK: begin
          found_q  <= 1'b0;
          scan_j_q <= '0;
          if (!second_q) begin
            a_q      <= best_q;
            wa_q     <= best_w_q;
            second_q <= 1'b1;
            state_q  <= S_SCAN;
          end else begin
            second_q <= 1'b0;
            if (bi_q == root) begin
              walk_q       <= root;
              emitted_q    <= '0;
              tree_ready_q <= 1'b1;
              state_q      <= S_IDLE;
            end else begin
              bi_q    <= bi_q + 1'b1;
              state_q <= S_SCAN;
            end
          end
        end
        // one bit step: read the current node's children, or end the byte
        S_DEC: begin
          if (bit_q == 4'd8) begin
            state_q <= S_FIN;
          end else if (total_hit) begin
            walk_q  <= root;
            state_q <= S_FIN;
          end else begin
            state_q <= S_DCH;
          end
        end
        S_DCH: begin
          if (nxt < bn_q) begin
            new_done_q <= (emitted_q + 32'd1) == symbol_total_q;
            emitted_q  <= emitted_q + 32'd1;
            state_q    <= S_DSYM;
          end else begin
            walk_q  <= nxt;
            byte_q  <= {byte_q[6:0], 1'b0};
            bit_q   <= bit_q + 1'b1;
            state_q <= S_DEC;
          end
        end
        // leaf reached: older held symbol goes out, new one is held
        S_DSYM: begin
          if (!hold_valid_q || out_free) begin
            if (hold_valid_q) begin
              out_valid_q <= 1'b1;
              out_sym_q   <= hold_sym_q;
              out_last_q  <= 1'b0;
              out_done_q  <= hold_done_q;
            end
            hold_valid_q <= 1'b1;
            hold_sym_q   <= sym_rdata;
            hold_done_q  <= new_done_q;
            walk_q       <= root;
            byte_q       <= {byte_q[6:0], 1'b0};
            bit_q        <= bit_q + 1'b1;
            state_q      <= S_DEC;
          end
        end
        // byte done: flush the held symbol as last of byte
        S_FIN: begin
          if (!hold_valid_q) begin
            state_q <= S_IDLE;
          end else if (out_free) begin
            out_valid_q  <= 1'b1;
            out_sym_q    <= hold_sym_q;
            out_last_q   <= 1'b1;
            out_done_q   <= hold_done_q;
            hold_valid_q <= 1'b0;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign symbol_out_o   = out_sym_q;
  assign last_of_byte_o = out_last_q;
  assign stream_done_o  = out_done_q;
endmodule

[rtl/hbd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module hbd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

[rtl/hbd_checker.sv]
// Port-level checker for the Huffman build and decode top, with its bind.
`timescale 1ns / 1ps
module hbd_checker
  import hbd_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [1:0] mode_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] symbol_out_o,
  input logic       pready
);
  // a stalled result transfer holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(symbol_out_o))
    else $error("stalled result changed");

  // config port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

  // load or build transfers never start a result
  a_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (mode_i == MODE_LOAD || mode_i == MODE_BUILD)
    |=> !$rose(out_valid_o))
    else $error("result after non-decode transfer");
endmodule

bind huffman_tree_build_and_decode_top hbd_checker u_hbd_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .mode_i, .out_valid_o,
  .out_ready_i, .symbol_out_o, .pready);
